// ----- sv/cme_pkg.sv -----
// ============================================================================
// cme_pkg: shared types and constants of the cubic magnetoelastic field block
// Item structs, datapath select codes, sequencer word and saturation limits.
// ============================================================================
`default_nettype none

package cme_pkg;

    // Fixed field widths.
    localparam int unsigned MS_W  = 22;
    localparam int unsigned A_W   = 96;   // wide multiplicand, three 32-bit chunks
    localparam int unsigned B_W   = 37;   // narrow multiplier operand
    localparam int unsigned MAG_W = 80;   // magnitude of the field numerator

    // Multiply-accumulate sequencing.
    localparam int unsigned MAC_CHUNKS   = 3;
    localparam int unsigned DIV_STEPS    = 8;
    localparam int unsigned DIV_BITS     = 4;
    localparam int unsigned CFG_IDX_W    = 3;

    // round(2^16 / mu0)
    localparam logic [35:0] INV_MU0_Q16 = 36'd52151891752;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B1          = 3'd0,
        CFG_B2          = 3'd1,
        CFG_UNIFORM_MS  = 3'd2,
        CFG_USE_NODE_MS = 3'd3,
        CFG_COUPLING_ON = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
        logic signed [31:0] strain_xx;
        logic signed [31:0] strain_yy;
        logic signed [31:0] strain_zz;
        logic signed [31:0] shear_yz;
        logic signed [31:0] shear_xz;
        logic signed [31:0] shear_xy;
        logic [MS_W-1:0]    node_ms;
        logic [31:0]        node_weight;
        logic [1:0]         node_flags;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
        logic signed [63:0] energy_total;
        logic               last_node;
    } t_out_item;

    typedef enum logic [3:0] {
        A_EXX, A_EYY, A_EZZ, A_GYZ, A_GXZ, A_GXY,
        A_DX, A_DY, A_DZ, A_DX2, A_DY2, A_DZ2,
        A_OX, A_TW, A_MAG
    } t_a_sel;

    typedef enum logic [2:0] {
        B_MX, B_MY, B_MZ, B_B1, B_B2, B_INV, B_WGT
    } t_b_sel;

    typedef enum logic [3:0] {
        D_NONE, D_DX, D_DY, D_DZ, D_OX, D_TW, D_MAG, D_D16, D_ENG,
        D_FX, D_FY, D_FZ
    } t_dst;

    typedef struct packed {
        logic   is_div;
        logic   clr;
        t_a_sel a_sel;
        t_b_sel b_sel;
        t_dst   dst;
        logic   last;
    } t_uop;

    // Controller to datapath.
    typedef struct packed {
        logic       load;
        logic       mul;
        logic [1:0] chunk;
        logic       add;
        logic [1:0] add_chunk;
        logic       clr;
        t_a_sel     a_sel;
        t_b_sel     b_sel;
        logic       wr;
        t_dst       dst;
        logic       div_init;
        logic       div_step;
        logic       commit;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic active;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- sv/cme_ctrl.sv -----
// ============================================================================
// cme_ctrl: sequencer of the cubic magnetoelastic field block
// Walks the per-node operation program and drives the shared datapath.
// ============================================================================
`default_nettype none

module cme_ctrl import cme_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_MAC    = 5'b00100,
        S_DIV    = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    function automatic t_uop mk(input logic is_div, input logic clr, input t_a_sel a,
                                input t_b_sel b, input t_dst d, input logic last);
        t_uop u;
        u.is_div = is_div;
        u.clr    = clr;
        u.a_sel  = a;
        u.b_sel  = b;
        u.dst    = d;
        u.last   = last;
        return u;
    endfunction

    // Operation program for one active node: three field components, then energy.
    function automatic t_uop uop_at(input logic [4:0] pc);
        t_uop u;
        case (pc)
            5'd0:  u = mk(1'b0, 1'b1, A_EXX, B_MX,  D_DX,   1'b0);
            5'd1:  u = mk(1'b0, 1'b1, A_GXY, B_MY,  D_NONE, 1'b0);
            5'd2:  u = mk(1'b0, 1'b0, A_GXZ, B_MZ,  D_OX,   1'b0);
            5'd3:  u = mk(1'b0, 1'b1, A_DX2, B_B1,  D_NONE, 1'b0);
            5'd4:  u = mk(1'b0, 1'b0, A_OX,  B_B2,  D_MAG,  1'b0);
            5'd5:  u = mk(1'b0, 1'b1, A_MAG, B_INV, D_NONE, 1'b0);
            5'd6:  u = mk(1'b1, 1'b0, A_MAG, B_INV, D_FX,   1'b0);
            5'd7:  u = mk(1'b0, 1'b1, A_EYY, B_MY,  D_DY,   1'b0);
            5'd8:  u = mk(1'b0, 1'b1, A_GXY, B_MX,  D_NONE, 1'b0);
            5'd9:  u = mk(1'b0, 1'b0, A_GYZ, B_MZ,  D_TW,   1'b0);
            5'd10: u = mk(1'b0, 1'b1, A_DY2, B_B1,  D_NONE, 1'b0);
            5'd11: u = mk(1'b0, 1'b0, A_TW,  B_B2,  D_MAG,  1'b0);
            5'd12: u = mk(1'b0, 1'b1, A_MAG, B_INV, D_NONE, 1'b0);
            5'd13: u = mk(1'b1, 1'b0, A_MAG, B_INV, D_FY,   1'b0);
            5'd14: u = mk(1'b0, 1'b1, A_EZZ, B_MZ,  D_DZ,   1'b0);
            5'd15: u = mk(1'b0, 1'b1, A_GXZ, B_MX,  D_NONE, 1'b0);
            5'd16: u = mk(1'b0, 1'b0, A_GYZ, B_MY,  D_TW,   1'b0);
            5'd17: u = mk(1'b0, 1'b1, A_DZ2, B_B1,  D_NONE, 1'b0);
            5'd18: u = mk(1'b0, 1'b0, A_TW,  B_B2,  D_MAG,  1'b0);
            5'd19: u = mk(1'b0, 1'b1, A_MAG, B_INV, D_NONE, 1'b0);
            5'd20: u = mk(1'b1, 1'b0, A_MAG, B_INV, D_FZ,   1'b0);
            5'd21: u = mk(1'b0, 1'b1, A_GYZ, B_MZ,  D_TW,   1'b0);
            5'd22: u = mk(1'b0, 1'b1, A_TW,  B_MY,  D_NONE, 1'b0);
            5'd23: u = mk(1'b0, 1'b0, A_OX,  B_MX,  D_TW,   1'b0);
            5'd24: u = mk(1'b0, 1'b1, A_DX,  B_MX,  D_NONE, 1'b0);
            5'd25: u = mk(1'b0, 1'b0, A_DY,  B_MY,  D_NONE, 1'b0);
            5'd26: u = mk(1'b0, 1'b0, A_DZ,  B_MZ,  D_DX,   1'b0);
            5'd27: u = mk(1'b0, 1'b1, A_DX,  B_B1,  D_NONE, 1'b0);
            5'd28: u = mk(1'b0, 1'b0, A_TW,  B_B2,  D_D16,  1'b0);
            5'd29: u = mk(1'b0, 1'b1, A_TW,  B_WGT, D_ENG,  1'b1);
            default: u = mk(1'b0, 1'b0, A_EXX, B_MX, D_NONE, 1'b1);
        endcase
        return u;
    endfunction

    t_state     r_state, n_state;
    logic [4:0] r_pc, n_pc;
    logic [1:0] r_chunk, n_chunk;
    logic [3:0] r_dcnt, n_dcnt;
    t_uop       w_u;
    t_uop       w_u_next;

    always_comb begin
        w_u      = uop_at(r_pc);
        w_u_next = uop_at(5'(r_pc + 5'd1));
        n_state  = r_state;
        n_pc     = r_pc;
        n_chunk  = r_chunk;
        n_dcnt   = r_dcnt;
        o_cmd    = '0;
        o_cmd.a_sel = w_u.a_sel;
        o_cmd.b_sel = w_u.b_sel;
        o_cmd.dst   = w_u.dst;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_pc    = '0;
                n_chunk = '0;
                n_dcnt  = '0;
                n_state = i_sts.active ? S_MAC : S_COMMIT;
            end
            S_MAC: begin
                o_cmd.mul       = (r_chunk != 2'(MAC_CHUNKS));
                o_cmd.chunk     = r_chunk;
                o_cmd.add       = (r_chunk != 2'd0);
                o_cmd.add_chunk = 2'(r_chunk - 2'd1);
                o_cmd.clr       = w_u.clr && (r_chunk == 2'd1);
                o_cmd.wr        = (r_chunk == 2'(MAC_CHUNKS));
                if (r_chunk == 2'(MAC_CHUNKS)) begin
                    n_chunk = '0;
                    n_dcnt  = '0;
                    if (w_u.last) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_pc    = 5'(r_pc + 5'd1);
                        n_state = w_u_next.is_div ? S_DIV : S_MAC;
                    end
                end else begin
                    n_chunk = 2'(r_chunk + 2'd1);
                end
            end
            S_DIV: begin
                o_cmd.div_init = (r_dcnt == 4'd0);
                o_cmd.div_step = (r_dcnt != 4'd0);
                o_cmd.wr       = (r_dcnt == 4'(DIV_STEPS));
                if (r_dcnt == 4'(DIV_STEPS)) begin
                    n_dcnt  = '0;
                    n_chunk = '0;
                    n_pc    = 5'(r_pc + 5'd1);
                    n_state = w_u_next.is_div ? S_DIV : S_MAC;
                end else begin
                    n_dcnt = 4'(r_dcnt + 4'd1);
                end
            end
            S_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_chunk <= '0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_chunk <= n_chunk;
            r_dcnt  <= n_dcnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- sv/cme_dp.sv -----
// ============================================================================
// cme_dp: datapath of the cubic magnetoelastic field block
// Shared chunked multiplier with accumulator, temporaries, divider, output.
// ============================================================================
`default_nettype none

module cme_dp import cme_pkg::*; #(
    parameter int unsigned STRAIN_FRAC_BITS = 36
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire t_in_item           i_in_data,
    input  wire logic signed [31:0] i_b1,
    input  wire logic signed [31:0] i_b2,
    input  wire logic [MS_W-1:0]    i_uniform_ms,
    input  wire logic               i_use_node_ms,
    input  wire logic               i_coupling_on,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output t_out_item               o_out_data
);

    localparam int unsigned ACC_W  = 120;
    localparam int unsigned ACH_W  = 33;
    localparam int unsigned PROD_W = ACH_W + B_W;
    localparam int unsigned D16_SH = 14 + STRAIN_FRAC_BITS;
    localparam int unsigned DIV_SH = 31 + STRAIN_FRAC_BITS;
    localparam int unsigned HI_W   = ACC_W - DIV_SH - 32;
    localparam int unsigned CMP_W  = (HI_W > MS_W) ? HI_W : MS_W;

    t_in_item                  r_item;
    logic [MS_W-1:0]           r_ms;
    logic                      r_active;
    logic                      r_last;
    logic signed [63:0]        r_dx;
    logic signed [47:0]        r_dy;
    logic signed [47:0]        r_dz;
    logic signed [48:0]        r_ox;
    logic signed [63:0]        r_tw;
    logic [MAG_W-1:0]          r_mag;
    logic                      r_neg;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic [MS_W-1:0]           r_rem;
    logic [31:0]               r_dq;
    logic                      r_ovf;
    logic signed [31:0]        r_fx, r_fy, r_fz;
    logic signed [63:0]        r_energy;
    t_out_item                 r_out;
    logic                      r_out_valid;

    logic [MS_W-1:0]           w_sel_ms;
    logic signed [A_W-1:0]     w_a;
    logic signed [B_W-1:0]     w_b;
    logic signed [ACH_W-1:0]   w_ach;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_addend;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   w_nabs;
    logic signed [ACC_W-1:0]   w_dsh;
    logic signed [63:0]        w_d16;
    logic signed [63:0]        w_eprod;
    logic signed [64:0]        w_esum_x;
    logic signed [63:0]        w_esum;
    logic [CMP_W-1:0]          w_hi_ext;
    logic [MS_W-1:0]           n_rem;
    logic [31:0]               n_dq;
    logic [MS_W:0]             w_t;
    logic                      w_sat;
    logic signed [31:0]        w_field;
    logic                      w_out_free;

    assign w_sel_ms = i_use_node_ms ? i_in_data.node_ms : i_uniform_ms;

    // Operand selection.
    always_comb begin
        case (i_cmd.a_sel)
            A_EXX:   w_a = A_W'($signed(r_item.strain_xx));
            A_EYY:   w_a = A_W'($signed(r_item.strain_yy));
            A_EZZ:   w_a = A_W'($signed(r_item.strain_zz));
            A_GYZ:   w_a = A_W'($signed(r_item.shear_yz));
            A_GXZ:   w_a = A_W'($signed(r_item.shear_xz));
            A_GXY:   w_a = A_W'($signed(r_item.shear_xy));
            A_DX:    w_a = A_W'(r_dx);
            A_DY:    w_a = A_W'(r_dy);
            A_DZ:    w_a = A_W'(r_dz);
            A_DX2:   w_a = A_W'(r_dx) <<< 1;
            A_DY2:   w_a = A_W'(r_dy) <<< 1;
            A_DZ2:   w_a = A_W'(r_dz) <<< 1;
            A_OX:    w_a = A_W'(r_ox);
            A_TW:    w_a = A_W'(r_tw);
            A_MAG:   w_a = $signed(A_W'(r_mag));
            default: w_a = '0;
        endcase
        case (i_cmd.b_sel)
            B_MX:    w_b = B_W'($signed(r_item.mag_x));
            B_MY:    w_b = B_W'($signed(r_item.mag_y));
            B_MZ:    w_b = B_W'($signed(r_item.mag_z));
            B_B1:    w_b = B_W'(i_b1);
            B_B2:    w_b = B_W'(i_b2);
            B_INV:   w_b = $signed(B_W'(INV_MU0_Q16));
            B_WGT:   w_b = $signed(B_W'(r_item.node_weight));
            default: w_b = '0;
        endcase
        // Low chunks are unsigned, the top chunk carries the sign.
        case (i_cmd.chunk)
            2'd0:    w_ach = $signed({1'b0, w_a[31:0]});
            2'd1:    w_ach = $signed({1'b0, w_a[63:32]});
            default: w_ach = $signed({w_a[A_W-1], w_a[A_W-1:64]});
        endcase
    end

    assign w_prod = w_ach * w_b;

    always_comb begin
        case (i_cmd.add_chunk)
            2'd0:    w_addend = ACC_W'(r_prod);
            2'd1:    w_addend = ACC_W'(r_prod) <<< 32;
            default: w_addend = ACC_W'(r_prod) <<< 64;
        endcase
        n_acc = (i_cmd.clr ? '0 : r_acc) + w_addend;

        w_nabs = n_acc[ACC_W-1] ? -n_acc : n_acc;

        // Energy density in 2^-16 J/m^3, floor shift and clip to 64 bits.
        w_dsh = n_acc >>> D16_SH;
        if ((&w_dsh[ACC_W-1:63]) || !(|w_dsh[ACC_W-1:63])) begin
            w_d16 = w_dsh[63:0];
        end else begin
            w_d16 = w_dsh[ACC_W-1] ? S64_MIN : S64_MAX;
        end

        if ((&n_acc[ACC_W-1:63]) || !(|n_acc[ACC_W-1:63])) begin
            w_eprod = n_acc[63:0];
        end else begin
            w_eprod = n_acc[ACC_W-1] ? S64_MIN : S64_MAX;
        end
        w_esum_x = 65'(r_energy) + 65'(w_eprod);
        if (w_esum_x[64] != w_esum_x[63]) begin
            w_esum = w_esum_x[64] ? S64_MIN : S64_MAX;
        end else begin
            w_esum = w_esum_x[63:0];
        end
    end

    // Radix-16 restoring divider over the shifted product.
    assign w_hi_ext = CMP_W'(r_acc[ACC_W-1:DIV_SH+32]);

    always_comb begin
        n_rem = r_rem;
        n_dq  = r_dq;
        w_t   = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            w_t  = {n_rem, n_dq[31]};
            n_dq = {n_dq[30:0], 1'b0};
            if (w_t >= {1'b0, r_ms}) begin
                n_rem   = MS_W'(w_t - {1'b0, r_ms});
                n_dq[0] = 1'b1;
            end else begin
                n_rem = w_t[MS_W-1:0];
            end
        end
        w_sat = r_ovf | n_dq[31];
        if (r_neg) begin
            w_field = w_sat ? S32_MAX : $signed(n_dq);
        end else begin
            w_field = w_sat ? S32_MIN : -$signed(n_dq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item   <= i_in_data;
            r_ms     <= w_sel_ms;
            r_active <= i_coupling_on && i_in_data.node_flags[0] && (w_sel_ms != '0);
            r_last   <= i_in_data.node_flags[1];
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.add) begin
            r_acc <= n_acc;
        end
        if (i_cmd.div_init) begin
            r_ovf <= (w_hi_ext >= CMP_W'(r_ms));
            r_rem <= w_hi_ext[MS_W-1:0];
            r_dq  <= r_acc[DIV_SH +: 32];
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dq  <= n_dq;
        end
        if (i_cmd.wr) begin
            case (i_cmd.dst)
                D_DX:  r_dx <= n_acc[63:0];
                D_DY:  r_dy <= n_acc[47:0];
                D_DZ:  r_dz <= n_acc[47:0];
                D_OX:  r_ox <= n_acc[48:0];
                D_TW:  r_tw <= n_acc[63:0];
                D_MAG: begin
                    r_mag <= w_nabs[MAG_W-1:0];
                    r_neg <= n_acc[ACC_W-1];
                end
                D_D16: r_tw <= w_d16;
                D_FX:  r_fx <= w_field;
                D_FY:  r_fy <= w_field;
                D_FZ:  r_fz <= w_field;
                default: ;
            endcase
        end
        if (i_cmd.commit) begin
            r_out.field_x      <= r_active ? r_fx : '0;
            r_out.field_y      <= r_active ? r_fy : '0;
            r_out.field_z      <= r_active ? r_fz : '0;
            r_out.energy_total <= r_energy;
            r_out.last_node    <= r_last;
        end
    end

    // Running energy total, cleared after the last node of a pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= '0;
        end else if (i_cmd.wr && (i_cmd.dst == D_ENG)) begin
            r_energy <= w_esum;
        end else if (i_cmd.commit && r_last) begin
            r_energy <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign w_out_free     = !r_out_valid || !i_out_stall;
    assign o_sts.active   = r_active;
    assign o_sts.out_free = w_out_free;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

`default_nettype wire

// ----- sv/cubic_magnetoelastic_field.sv -----
// ============================================================================
// cubic_magnetoelastic_field: cubic B1/B2 magnetoelastic field and energy sum
// Per mesh node field -(1/(mu0 Ms)) dE/dm with a saturating weighted energy total.
// ============================================================================
// One node is taken per transfer and gives one result transfer. An active node
// (coupling on, magnetic flag set, selected Ms not zero) occupies the block for
// 27 multiply-accumulate operations on the single shared 33 x 37 bit multiplier,
// three divisions by Ms in the radix-16 divider, a step to qualify the node and
// one to hand the result to the output register. An inactive node is only
// qualified and handed on. The output register holds a finished result while the
// next node is taken in, so a stalled consumer only blocks the block when a
// second result is ready. The energy total reports the running sum including the
// current node, is final on the node flagged last, and is cleared after it.
// Configuration is written through a simple always-ready write channel; the user
// must write it only while the block is idle, which the block does not enforce.
`default_nettype none

module cubic_magnetoelastic_field import cme_pkg::*; #(
    parameter int unsigned STRAIN_FRAC_BITS = 36
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Node input channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    // Result channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    // Configuration write channel.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    logic signed [31:0] r_b1;
    logic signed [31:0] r_b2;
    logic [MS_W-1:0]    r_uniform_ms;
    logic               r_use_node_ms;
    logic               r_coupling_on;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1          <= '0;
            r_b2          <= '0;
            r_uniform_ms  <= '0;
            r_use_node_ms <= 1'b0;
            r_coupling_on <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_B1:          r_b1          <= i_cfg_data;
                CFG_B2:          r_b2          <= i_cfg_data;
                CFG_UNIFORM_MS:  r_uniform_ms  <= i_cfg_data[MS_W-1:0];
                CFG_USE_NODE_MS: r_use_node_ms <= i_cfg_data[0];
                CFG_COUPLING_ON: r_coupling_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The sequencer owns the input handshake and steps the datapath program.
    cme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the node, the arithmetic and the result register.
    cme_dp #(
        .STRAIN_FRAC_BITS (STRAIN_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_in_data     (i_in_data),
        .i_b1          (r_b1),
        .i_b2          (r_b2),
        .i_uniform_ms  (r_uniform_ms),
        .i_use_node_ms (r_use_node_ms),
        .i_coupling_on (r_coupling_on),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule

`default_nettype wire
